@@ rtl/swm_pkg.sv @@
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and fixed widths for the sliding window median filter.
// ----------------------------------------------------------------------------
package swm_pkg;

    // Fixed widths of the ports
    localparam int SAMPLE_PORT_W  = 32;
    localparam int MEDIAN_W       = 33;
    localparam int WINDOW_SIZE_W  = 7;

    localparam logic [WINDOW_SIZE_W-1:0] WINDOW_SIZE_RESET = 7'd3;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic update;   // cells load their next value this cycle
        logic insert;   // a new sample enters; ages advance
    } swm_ctl_t;

endpackage

@@ rtl/swm_cell.sv @@
// ----------------------------------------------------------------------------
// swm_cell
// One slot of the sorted window: holds a sample and its age, removes
// itself when expired by pulling from the right, and makes room for an
// inserted sample by pulling from the left.
// ----------------------------------------------------------------------------
module swm_cell #(
    parameter int SW = 32,
    parameter int AW = 6,
    parameter int WW = 7
) (
    input  logic                  aclk,
    input  swm_pkg::swm_ctl_t     ctl,
    input  logic [WW-1:0]         win,
    input  logic signed [SW-1:0]  new_value,
    input  logic                  live,
    input  logic                  live_d,
    input  logic                  seen_in,
    input  logic signed [SW-1:0]  right_value,
    input  logic [AW-1:0]         right_age,
    input  logic signed [SW-1:0]  left_d_value,
    input  logic [AW-1:0]         left_d_age,
    input  logic                  left_gt,
    output logic signed [SW-1:0]  value,
    output logic [AW-1:0]         age,
    output logic                  seen_out,
    output logic                  multi,
    output logic signed [SW-1:0]  d_value,
    output logic [AW-1:0]         d_age,
    output logic                  gt
);
    import swm_pkg::*;

    logic signed [SW-1:0] value_reg, value_next;
    logic [AW-1:0]        age_reg, age_next;
    logic [WW-1:0]        age_inc;
    logic                 expired;
    logic                 shift;

    assign value = value_reg;
    assign age   = age_reg;

    // Flag an entry whose next age would fall outside the window
    assign age_inc  = WW'(age_reg) + WW'(1);
    assign expired  = live && (age_inc >= win);
    assign seen_out = seen_in | expired;
    assign multi    = expired & seen_in;

    // Close the gap left by the first expired entry at or to the left
    assign shift   = seen_out;
    assign d_value = shift ? right_value : value_reg;
    assign d_age   = shift ? right_age : age_reg;

    // Empty slots count as larger than any sample
    assign gt = !live_d || (new_value < d_value);

    // Select the next content: compacted, inserted or shifted right
    always_comb begin
        value_next = d_value;
        age_next   = d_age;
        if (ctl.insert) begin
            if (gt) begin
                if (left_gt) begin
                    value_next = left_d_value;
                    age_next   = left_d_age + AW'(1);
                end else begin
                    value_next = new_value;
                    age_next   = '0;
                end
            end else begin
                age_next = d_age + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.update) begin
            value_reg <= value_next;
            age_reg   <= age_next;
        end
    end

endmodule

@@ rtl/swm_out_fifo.sv @@
// ----------------------------------------------------------------------------
// swm_out_fifo
// Two-entry result queue between the median stage and the output channel.
// ----------------------------------------------------------------------------
module swm_out_fifo (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  logic [swm_pkg::MEDIAN_W-1:0]  push_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [swm_pkg::MEDIAN_W-1:0]  m_data,
    output logic [1:0]                    count
);
    import swm_pkg::*;

    logic [MEDIAN_W-1:0] head_reg, head_next;
    logic [MEDIAN_W-1:0] tail_reg, tail_next;
    logic [1:0]          count_reg, count_next;
    logic                pop;

    assign m_valid = (count_reg != 2'd0);
    assign m_data  = head_reg;
    assign count   = count_reg;
    assign pop     = m_valid && m_ready;

    // Advance the queue on pop, fill the first free slot on push
    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        case ({push, pop})
            2'b10: begin
                if (count_reg == 2'd0) begin
                    head_next = push_data;
                end else begin
                    tail_next = push_data;
                end
                count_next = count_reg + 2'd1;
            end
            2'b01: begin
                head_next  = tail_reg;
                count_next = count_reg - 2'd1;
            end
            2'b11: begin
                if (count_reg == 2'd1) begin
                    head_next = push_data;
                end else begin
                    head_next = tail_reg;
                    tail_next = push_data;
                end
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

@@ rtl/sliding_window_median.sv @@
// ----------------------------------------------------------------------------
// sliding_window_median
// Exact median over the last window_size samples, given doubled.
// ----------------------------------------------------------------------------
// The window is a chain of MAX_WINDOW cells kept in ascending order, each
// holding one sample and its age. When an item is taken, an entry that has
// fallen out of the window, if any, leaves the chain and the new sample is
// inserted in sorted order in the same update. When window_size has been
// lowered, every entry beyond the first that falls out of the window holds
// off the next item, unless it starts a sequence, since the chain closes one
// gap per cycle while an item is offered. An item is also held off while the
// output queue, counting the result still being formed, would have no free
// slot. Once the window holds window_size samples, each item yields one
// result. The cells update at the edge that takes it; at the next edge the
// median is read, added and written into a two-entry output queue, where it
// is valid on the output: twice the middle sample for an odd window, the sum
// of the two middle samples for an even one. A set first_of_sequence empties
// the window before its sample. window_size 0 acts as 1, and values above
// MAX_WINDOW act as MAX_WINDOW. Write window_size only while no item is in flight.
// ----------------------------------------------------------------------------
module sliding_window_median #(
    parameter int MAX_WINDOW   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [swm_pkg::WINDOW_SIZE_W-1:0]  cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [swm_pkg::SAMPLE_PORT_W-1:0]  s_sample,
    input  logic                               s_first_of_sequence,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [swm_pkg::MEDIAN_W-1:0]       m_median_doubled
);
    import swm_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WW = $clog2(MAX_WINDOW + 1);
    localparam int IW = AW;
    localparam int CW = (WW > WINDOW_SIZE_W) ? WW : WINDOW_SIZE_W;

    logic [WINDOW_SIZE_W-1:0] window_size_reg;
    logic [WW-1:0]            fill_reg, fill_next;
    logic                     pend_reg;

    logic [CW-1:0]            ws_ext;
    logic [WW-1:0]            win_eff;
    logic [WW-1:0]            fill_d;
    logic [WW-1:0]            fill_ins;
    logic signed [SW-1:0]     sample_trim;

    logic signed [SW-1:0] cell_value   [MAX_WINDOW];
    logic [AW-1:0]        cell_age     [MAX_WINDOW];
    logic signed [SW-1:0] cell_d_value [MAX_WINDOW];
    logic [AW-1:0]        cell_d_age   [MAX_WINDOW];
    logic signed [SW-1:0] left_value   [MAX_WINDOW];
    logic [AW-1:0]        left_age     [MAX_WINDOW];
    logic signed [SW-1:0] right_value  [MAX_WINDOW];
    logic [AW-1:0]        right_age    [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] cell_gt, left_gt, cell_live, cell_live_d;
    logic [MAX_WINDOW-1:0] cell_multi;
    logic [MAX_WINDOW:0]   cell_seen;

    logic       any_exp, multi_any;
    logic       accept, purge, clear, pop;
    logic [1:0] q_count, q_after;
    swm_ctl_t   ctl;

    logic [WW-1:0]         hi_full;
    logic [IW-1:0]         hi_idx, lo_idx;
    logic signed [SW-1:0]  med_hi, med_lo;
    logic [SW:0]           med2_bits;
    logic [MEDIAN_W-1:0]   median_word;

    // Clamp the window size to the supported range
    assign ws_ext  = CW'(window_size_reg);
    assign win_eff = (window_size_reg == '0)        ? WW'(1) :
                     (ws_ext > CW'(MAX_WINDOW))    ? WW'(MAX_WINDOW) :
                                                     WW'(ws_ext);

    assign sample_trim = s_sample[SW-1:0];

    // Handshake: take an item when the queue has room and the chain needs at most one
    // removal or the item starts a sequence; while an item waits on more removals, drop one expired entry per cycle
    assign any_exp   = cell_seen[MAX_WINDOW];
    assign multi_any = |cell_multi;
    assign pop       = m_valid && m_ready;
    assign q_after   = q_count - {1'b0, pop} + {1'b0, pend_reg};
    assign s_ready   = (q_after <= 2'd1) && (s_first_of_sequence || !multi_any);
    assign accept    = s_valid && s_ready;
    assign purge     = s_valid && !s_first_of_sequence && multi_any;
    assign clear     = accept && s_first_of_sequence;

    assign ctl.update = accept || purge;
    assign ctl.insert = accept;

    assign fill_d   = clear ? '0 : (fill_reg - WW'(any_exp));
    assign fill_ins = fill_d + WW'(1);

    assign cell_seen[0] = 1'b0;

    // Build the cell chain
    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        assign cell_live[g]   = WW'(g) < fill_reg;
        assign cell_live_d[g] = !clear && (WW'(g) < fill_d);

        if (g == 0) begin : g_first
            assign left_value[g] = '0;
            assign left_age[g]   = '0;
            assign left_gt[g]    = 1'b0;
        end else begin : g_mid
            assign left_value[g] = cell_d_value[g-1];
            assign left_age[g]   = cell_d_age[g-1];
            assign left_gt[g]    = cell_gt[g-1];
        end

        if (g == MAX_WINDOW - 1) begin : g_last
            assign right_value[g] = '0;
            assign right_age[g]   = '0;
        end else begin : g_inner
            assign right_value[g] = cell_value[g+1];
            assign right_age[g]   = cell_age[g+1];
        end

        swm_cell #(
            .SW (SW),
            .AW (AW),
            .WW (WW)
        ) u_cell (
            .aclk         (aclk),
            .ctl          (ctl),
            .win          (win_eff),
            .new_value    (sample_trim),
            .live         (cell_live[g]),
            .live_d       (cell_live_d[g]),
            .seen_in      (cell_seen[g]),
            .right_value  (right_value[g]),
            .right_age    (right_age[g]),
            .left_d_value (left_value[g]),
            .left_d_age   (left_age[g]),
            .left_gt      (left_gt[g]),
            .value        (cell_value[g]),
            .age          (cell_age[g]),
            .seen_out     (cell_seen[g+1]),
            .multi        (cell_multi[g]),
            .d_value      (cell_d_value[g]),
            .d_age        (cell_d_age[g]),
            .gt           (cell_gt[g])
        );
    end

    // Track fill level, window size and the pending median
    always_comb begin
        fill_next = fill_reg;
        if (accept) begin
            fill_next = fill_ins;
        end else if (purge) begin
            fill_next = fill_reg - WW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg <= WINDOW_SIZE_RESET;
            fill_reg        <= '0;
            pend_reg        <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                window_size_reg <= cfg_wr_data;
            end
            fill_reg <= fill_next;
            pend_reg <= accept && (fill_ins == win_eff);
        end
    end

    // Read the middle cells and form twice the median
    assign hi_full = win_eff >> 1;
    assign hi_idx  = hi_full[IW-1:0];
    assign lo_idx  = hi_idx - IW'(1);
    assign med_hi  = cell_value[hi_idx];
    assign med_lo  = cell_value[lo_idx];
    assign med2_bits = win_eff[0] ? {med_hi, 1'b0}
                                  : ({med_hi[SW-1], med_hi} + {med_lo[SW-1], med_lo});
    assign median_word = MEDIAN_W'(med2_bits);

    swm_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (pend_reg),
        .push_data (median_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_median_doubled),
        .count     (q_count)
    );

`ifndef ASSERT_OFF
    a_result_full: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (fill_reg == win_eff))
        else $error("median taken from a window that is not full");

    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (fill_reg != '0) && (fill_reg <= $past(win_eff)))
        else $error("fill level out of range after an insert");

    a_purge_step: assert property (@(posedge aclk) disable iff (!aresetn)
        purge |=> (fill_reg == $past(fill_reg) - WW'(1)))
        else $error("purge did not remove exactly one entry");

    a_queue_room: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> ((q_count - {1'b0, pop}) <= 2'd1))
        else $error("result queue overflow");
`endif

endmodule

@@ tb/sliding_window_median_tb.sv @@
// ----------------------------------------------------------------------------
// sliding_window_median_tb
// Self-checking bench for the sliding window median filter.
// ----------------------------------------------------------------------------
// A short table of directed items runs first: full-scale samples, repeated
// values, sequence restarts, and window sizes of zero, one, two, odd, even and
// above the maximum. The window size is raised and lowered between rows. Rows
// whose result is obvious carry it typed in. The rest, and a long random run
// over many window settings, are checked against a behavioral model of the
// sorted window kept inside the bench. The sender works in bursts and the
// receiver stalls on its own changing pattern. The window size is written
// only after every pending result has come out and the chain has settled.
// ----------------------------------------------------------------------------
module sliding_window_median_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import swm_pkg::*;

    localparam int MAX_WIN     = 64;
    localparam int RAND_ITEMS  = 1000;
    localparam int SETTLE_CYC  = 100;   // quiet gap before a window write
    localparam int STALL_LIMIT = 1000;

    typedef enum {
        ROW_SILENT,      // window not full, no result
        ROW_TYPED,       // result given in the row
        ROW_PREDICTED    // result taken from the model
    } row_check_t;

    typedef struct {
        logic [WINDOW_SIZE_W-1:0] win;
        logic [SAMPLE_PORT_W-1:0] smp;
        bit                       sos;
        row_check_t               check;
        logic [MEDIAN_W-1:0]      lit;
    } stim_row_t;

    logic                      aclk;
    logic                      aresetn             = 1'b0;
    logic                      cfg_wr_en           = 1'b0;
    logic [WINDOW_SIZE_W-1:0]  cfg_wr_data         = '0;
    logic                      s_valid             = 1'b0;
    logic                      s_ready;
    logic [SAMPLE_PORT_W-1:0]  s_sample            = '0;
    logic                      s_first_of_sequence = 1'b0;
    logic                      m_valid;
    logic                      m_ready             = 1'b0;
    logic [MEDIAN_W-1:0]       m_median_doubled;

    sliding_window_median dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_sample            (s_sample),
        .s_first_of_sequence (s_first_of_sequence),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_median_doubled    (m_median_doubled)
    );

    // Model of the sorted window: values ascending, each with its age
    logic signed [SAMPLE_PORT_W-1:0] win_val [MAX_WIN];
    logic [5:0]                      win_age [MAX_WIN];
    int unsigned                     win_fill = 0;
    logic [WINDOW_SIZE_W-1:0]        win_size = WINDOW_SIZE_RESET;

    logic [MEDIAN_W-1:0] median_q [$];
    stim_row_t           dir_rows [$];
    int                  mismatches = 0;
    int                  quiet_cycles = 0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Advance the model by one sample; returns 1 when a median comes out
    function automatic bit window_median_step(input logic [SAMPLE_PORT_W-1:0] smp,
                                              input bit sos,
                                              output logic [MEDIAN_W-1:0] med2);
        int unsigned w;
        int unsigned kept;
        int unsigned pos;
        int unsigned lo;
        int unsigned hi;
        w = (win_size == 0) ? 1 : ((win_size > MAX_WIN) ? MAX_WIN : win_size);
        med2 = '0;
        if (sos)
            win_fill = 0;
        // drop entries that leave the window, age the rest
        kept = 0;
        for (int unsigned i = 0; i < win_fill; i++) begin
            if (win_age[i] + 1 < w) begin
                win_val[kept] = win_val[i];
                win_age[kept] = win_age[i] + 6'd1;
                kept++;
            end
        end
        win_fill = kept;
        // insert the new sample after any equal values
        pos = 0;
        while (pos < win_fill && win_val[pos] <= $signed(smp))
            pos++;
        for (int unsigned i = win_fill; i > pos; i--) begin
            win_val[i] = win_val[i-1];
            win_age[i] = win_age[i-1];
        end
        win_val[pos] = smp;
        win_age[pos] = '0;
        win_fill++;
        if (win_fill != w)
            return 1'b0;
        hi = w / 2;
        lo = w[0] ? hi : hi - 1;
        med2 = {win_val[lo][SAMPLE_PORT_W-1], win_val[lo]}
             + {win_val[hi][SAMPLE_PORT_W-1], win_val[hi]};
        return 1'b1;
    endfunction

    function automatic void add_row(input logic [WINDOW_SIZE_W-1:0] win,
                                    input logic [SAMPLE_PORT_W-1:0] smp,
                                    input bit sos, input row_check_t check,
                                    input logic [MEDIAN_W-1:0] lit);
        stim_row_t r;
        r.win   = win;
        r.smp   = smp;
        r.sos   = sos;
        r.check = check;
        r.lit   = lit;
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    // Offer one item and hold it until accepted, then record what it should yield
    task automatic send_item(input logic [SAMPLE_PORT_W-1:0] smp, input bit sos,
                             input row_check_t check, input logic [MEDIAN_W-1:0] lit);
        logic [MEDIAN_W-1:0] med2;
        bit                  has_med;
        @(negedge aclk);
        s_valid             <= 1'b1;
        s_sample            <= smp;
        s_first_of_sequence <= sos;
        do @(posedge aclk); while (!s_ready);
        has_med = window_median_step(smp, sos, med2);
        case (check)
            ROW_TYPED:     median_q.insert(median_q.size(), lit);
            ROW_PREDICTED: if (has_med) median_q.insert(median_q.size(), med2);
            default:       ;
        endcase
    endtask

    task automatic idle_sender(input int n);
        repeat (n) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    // Drain all pending medians, let the chain settle, then write the window size
    task automatic set_window(input logic [WINDOW_SIZE_W-1:0] w);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (median_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYC) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        win_size = w;
    endtask

    // Receiver: ready pattern whose style is redrawn at random from four modes
    int  rdy_mode = 0;
    int  rdy_hold = 0;
    bit  rdy_phase = 1'b0;
    int  rdy_cyc = 0;
    always @(negedge aclk) begin
        rdy_cyc++;
        if (rdy_cyc % 256 == 0)
            rdy_mode = $urandom_range(0, 3);
        case (rdy_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= rdy_cyc[0];
            default: begin
                if (rdy_hold == 0) begin
                    rdy_hold  = $urandom_range(1, 12);
                    rdy_phase = !rdy_phase;
                end
                rdy_hold--;
                m_ready <= rdy_phase;
            end
        endcase
    end

    // Compare each median with the oldest pending one; watch for a hung handshake
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (median_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected median, expected none, actual %h",
                             $time, m_median_doubled);
                end else begin
                    if (m_median_doubled !== median_q[0]) begin
                        mismatches++;
                        $display("%0t: median mismatch, expected %h, actual %h",
                                 $time, median_q[0], m_median_doubled);
                    end
                    void'(median_q.pop_front());
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        int                       sent;
        int                       w;
        int                       w_eff;
        int                       n;
        int                       burst;
        bit                       steady;
        bit                       sos;
        logic [SAMPLE_PORT_W-1:0] smp;

        for (int i = 0; i < MAX_WIN; i++) begin
            win_val[i] = '0;
            win_age[i] = '0;
        end

        // Directed rows: window, sample, restart, check, typed median
        add_row(7'd3,   32'h7FFF_FFFF, 1'b1, ROW_SILENT,    '0);
        add_row(7'd3,   32'h7FFF_FFFF, 1'b0, ROW_SILENT,    '0);
        add_row(7'd3,   32'h7FFF_FFFF, 1'b0, ROW_TYPED,     33'h0_FFFF_FFFE);
        add_row(7'd3,   32'h8000_0000, 1'b0, ROW_TYPED,     33'h0_FFFF_FFFE);
        add_row(7'd3,   32'h8000_0000, 1'b0, ROW_TYPED,     33'h1_0000_0000);
        add_row(7'd3,   32'h8000_0000, 1'b0, ROW_TYPED,     33'h1_0000_0000);
        add_row(7'd3,   32'd5,         1'b1, ROW_SILENT,    '0);
        add_row(7'd3,   32'd5,         1'b0, ROW_SILENT,    '0);
        add_row(7'd3,   32'd5,         1'b0, ROW_TYPED,     33'd10);
        add_row(7'd3,   32'hFFFF_FFFD, 1'b0, ROW_PREDICTED, '0);
        add_row(7'd1,   32'hFFFF_FFFF, 1'b0, ROW_TYPED,     33'h1_FFFF_FFFE);
        add_row(7'd1,   32'd0,         1'b1, ROW_TYPED,     33'd0);
        add_row(7'd0,   32'h1234_5678, 1'b0, ROW_TYPED,     33'h0_2468_ACF0);
        add_row(7'd2,   32'h7FFF_FFFF, 1'b0, ROW_PREDICTED, '0);
        add_row(7'd2,   32'h7FFF_FFFF, 1'b0, ROW_TYPED,     33'h0_FFFF_FFFE);
        add_row(7'd2,   32'h8000_0000, 1'b0, ROW_TYPED,     33'h1_FFFF_FFFF);
        add_row(7'd5,   32'd1,         1'b0, ROW_SILENT,    '0);
        add_row(7'd5,   32'd2,         1'b0, ROW_SILENT,    '0);
        add_row(7'd5,   32'd3,         1'b0, ROW_PREDICTED, '0);
        add_row(7'd5,   32'd3,         1'b0, ROW_PREDICTED, '0);
        add_row(7'd2,   32'd100,       1'b0, ROW_PREDICTED, '0);
        add_row(7'd127, 32'd0,         1'b1, ROW_SILENT,    '0);
        add_row(7'd4,   32'hFFFF_FFFF, 1'b1, ROW_SILENT,    '0);

        // Hold reset low, then release it
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Walk the directed rows
        foreach (dir_rows[i]) begin
            if (dir_rows[i].win != win_size)
                set_window(dir_rows[i].win);
            send_item(dir_rows[i].smp, dir_rows[i].sos, dir_rows[i].check, dir_rows[i].lit);
        end

        // Random phases, each with its own window size
        sent = 0;
        while (sent < RAND_ITEMS) begin
            case ($urandom_range(0, 15))
                0:       w = 0;
                1:       w = 1;
                2:       w = 2;
                3:       w = MAX_WIN;
                4:       w = 127;
                5:       w = $urandom_range(MAX_WIN + 1, 126);
                default: w = $urandom_range(3, 12);
            endcase
            set_window(WINDOW_SIZE_W'(w));
            w_eff  = (w == 0) ? 1 : ((w > MAX_WIN) ? MAX_WIN : w);
            n      = (w_eff > 12) ? w_eff + $urandom_range(10, 40) : $urandom_range(15, 60);
            steady = ($urandom_range(0, 3) == 0);
            burst  = 0;
            for (int k = 0; k < n; k++) begin
                if (burst == 0) begin
                    burst = $urandom_range(1, 24);
                    if (!steady)
                        idle_sender($urandom_range(0, 6));
                end
                burst--;
                case ($urandom_range(0, 9))
                    0: case ($urandom_range(0, 3))
                        0:       smp = 32'h7FFF_FFFF;
                        1:       smp = 32'h8000_0000;
                        2:       smp = 32'h0000_0000;
                        default: smp = 32'hFFFF_FFFF;
                    endcase
                    1, 2, 3: smp = 32'($urandom_range(0, 15)) - 32'd8;
                    default: smp = $urandom();
                endcase
                sos = ($urandom_range(0, 39) == 0);
                send_item(smp, sos, ROW_PREDICTED, '0);
            end
            sent += n;
        end

        // Drain and let the last items settle
        @(negedge aclk);
        s_valid <= 1'b0;
        while (median_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
